// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define XV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define XV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/xvkr_pkg.sv =====
// Package for the XOR key recovery unit: default sizes, register reset
// values, register indexes and the sequencer state type. No dependencies.
package xvkr_pkg;

  localparam int MSG_DEPTH_DEF = 1024;
  localparam int MAX_KEY_DEF   = 16;

  localparam logic [4:0]  MIN_LEN_RST  = 5'd6;
  localparam logic [4:0]  MAX_LEN_RST  = 5'd10;
  localparam logic [4:0]  FB_LEN_RST   = 5'd2;
  localparam logic [7:0]  PRIM_RST     = 8'd101;
  localparam logic [7:0]  SEC_RST      = 8'd32;
  localparam logic [15:0] MASK_RST     = 16'd13;

  typedef enum logic [2:0] {
    CFG_MIN_LEN   = 3'd0,
    CFG_MAX_LEN   = 3'd1,
    CFG_FB_LEN    = 3'd2,
    CFG_PRIM      = 3'd3,
    CFG_SEC       = 3'd4,
    CFG_MASK      = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K_INIT,
    ST_K_RD,
    ST_K_CMP,
    ST_K_NEXT,
    ST_C_CLR,
    ST_H_RD,
    ST_H_HR,
    ST_H_WR,
    ST_S_RD,
    ST_S_HR,
    ST_S_CMP,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/xvkr_if.sv =====
// Valid/ready channel interfaces for the XOR key recovery unit:
// ciphertext input, key output and register write. No dependencies.
interface xvkr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_byte;
  modport source (output valid, cipher_byte, last_byte, input ready);
  modport sink   (input valid, cipher_byte, last_byte, output ready);
endinterface

interface xvkr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic [3:0] key_position;
  logic [4:0] key_length;
  logic       overflowed;
  logic       last_key_byte;
  modport source (output valid, key_byte, key_position, key_length, overflowed,
                  last_key_byte, input ready);
  modport sink   (input valid, key_byte, key_position, key_length, overflowed,
                  last_key_byte, output ready);
endinterface

interface xvkr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/xor_vigenere_key_recovery_unit.sv =====
// Top level of the repeating-key XOR key recovery unit.
// Depends on xvkr_pkg and the channel interfaces in xvkr_if.sv.
//
// Usage:
//   in_ch  : ciphertext bytes, one request per byte, last_byte on the final one.
//   out_ch : one request per recovered key byte, positions 0..L-1 in order,
//            last_key_byte on the final one.
//   cfg_ch : register writes, always ready; write only while the unit is idle.
// Operation:
//   Loading takes one byte per cycle. Bytes past MSG_DEPTH are dropped and
//   flagged. After the last byte the input is not ready until the final key
//   byte is taken. The key length search reads each compared pair from the
//   two-port message memory, then compares it, for every shift tried.
//   Each key column then clears the 256-entry histogram RAM, makes one
//   read-modify-write pass and one read-and-compare pass over the column
//   bytes through the histogram RAM, then emits its key byte.
// Reset clears the byte count, overflow flag, sequencer and output valid and
// restores register defaults; the message memory is not cleared. When the
// receiver stalls, the key byte is held and the sequencer waits.
module xor_vigenere_key_recovery_unit
  import xvkr_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  parameter int MAX_KEY   = MAX_KEY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  xvkr_in_if.sink      in_ch,
  xvkr_out_if.source   out_ch,
  xvkr_cfg_if.sink     cfg_ch
);

  localparam int AW = $clog2(MSG_DEPTH);
  localparam int CW = $clog2(MSG_DEPTH + 1);
  localparam int IW = $clog2(MSG_DEPTH + MAX_KEY + 1);
  localparam int LW = $clog2(MAX_KEY + 1);

  function automatic logic [LW-1:0] clamp_len(input logic [4:0] v);
    logic [LW-1:0] r;
    if (v == 5'd0) r = LW'(1);
    else if (32'(v) > MAX_KEY) r = LW'(MAX_KEY);
    else r = LW'(v);
    return r;
  endfunction

  // registers
  logic [4:0]  min_len_r, max_len_r, fb_len_r;
  logic [7:0]  prim_r, sec_r;
  logic [15:0] mask_r;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [LW-1:0] k_r, k_nxt, hi_r, hi_nxt, len_r, len_nxt, col_r, col_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [CW-1:0] hits_r, hits_nxt, best_r, best_nxt, bestc_r, bestc_nxt;
  logic [7:0]  val_r, val_nxt, clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  okb_r, okb_nxt;
  logic [3:0]  opos_r, opos_nxt;
  logic [4:0]  olen_r, olen_nxt;
  logic        oovf_r, oovf_nxt, olast_r, olast_nxt;

  // memories
  logic [7:0]    msg_mem [MSG_DEPTH];
  logic [CW-1:0] hist_mem [256];
  logic [7:0]    qa_r, qb_r;
  logic [CW-1:0] hq_r;

  logic          m_we, m_re, h_we, h_re;
  logic [AW-1:0] m_wa, m_ra, m_rb;
  logic [7:0]    h_wa, h_ra;
  logic [CW-1:0] h_wd;

  logic          in_acc, is_full, prim_col, last_col;
  logic [IW-1:0] ik, i_step;
  logic [7:0]    guess;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign is_full = (cnt_r == CW'(MSG_DEPTH));
  assign ik      = i_r + IW'(k_r);
  assign i_step  = i_r + IW'(len_r);
  assign prim_col = (32'(col_r) < 16) && mask_r[4'(col_r)];
  assign guess    = prim_col ? prim_r : sec_r;
  assign last_col = ((col_r + 1'b1) == len_r);

  assign out_ch.valid         = ov_r;
  assign out_ch.key_byte      = okb_r;
  assign out_ch.key_position  = opos_r;
  assign out_ch.key_length    = olen_r;
  assign out_ch.overflowed    = oovf_r;
  assign out_ch.last_key_byte = olast_r;

  always_ff @(posedge clk) begin
    if (m_we) msg_mem[m_wa] <= in_ch.cipher_byte;
    if (m_re) begin
      qa_r <= msg_mem[m_ra];
      qb_r <= msg_mem[m_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    if (h_re) hq_r <= hist_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
      fb_len_r  <= FB_LEN_RST;
      prim_r    <= PRIM_RST;
      sec_r     <= SEC_RST;
      mask_r    <= MASK_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_MIN_LEN: min_len_r <= cfg_ch.data[4:0];
        CFG_MAX_LEN: max_len_r <= cfg_ch.data[4:0];
        CFG_FB_LEN:  fb_len_r  <= cfg_ch.data[4:0];
        CFG_PRIM:    prim_r    <= cfg_ch.data[7:0];
        CFG_SEC:     sec_r     <= cfg_ch.data[7:0];
        CFG_MASK:    mask_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    hi_r    <= hi_nxt;
    len_r   <= len_nxt;
    col_r   <= col_nxt;
    i_r     <= i_nxt;
    hits_r  <= hits_nxt;
    best_r  <= best_nxt;
    bestc_r <= bestc_nxt;
    val_r   <= val_nxt;
    clr_r   <= clr_nxt;
    okb_r   <= okb_nxt;
    opos_r  <= opos_nxt;
    olen_r  <= olen_nxt;
    oovf_r  <= oovf_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    hi_nxt    = hi_r;
    len_nxt   = len_r;
    col_nxt   = col_r;
    i_nxt     = i_r;
    hits_nxt  = hits_r;
    best_nxt  = best_r;
    bestc_nxt = bestc_r;
    val_nxt   = val_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    okb_nxt   = okb_r;
    opos_nxt  = opos_r;
    olen_nxt  = olen_r;
    oovf_nxt  = oovf_r;
    olast_nxt = olast_r;
    m_we = 1'b0;
    m_re = 1'b0;
    m_wa = cnt_r[AW-1:0];
    m_ra = i_r[AW-1:0];
    m_rb = ik[AW-1:0];
    h_we = 1'b0;
    h_re = 1'b0;
    h_wa = qa_r;
    h_ra = qa_r;
    h_wd = hq_r + 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_full) begin
            m_we    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_byte) state_nxt = ST_K_INIT;
        end
      end
      ST_K_INIT: begin
        k_nxt    = clamp_len(min_len_r);
        hi_nxt   = clamp_len(max_len_r);
        len_nxt  = clamp_len(fb_len_r);
        best_nxt = '0;
        hits_nxt = '0;
        i_nxt    = '0;
        col_nxt  = '0;
        clr_nxt  = '0;
        if (clamp_len(min_len_r) > clamp_len(max_len_r)) state_nxt = ST_C_CLR;
        else state_nxt = ST_K_RD;
      end
      ST_K_RD: begin
        if (ik < IW'(cnt_r)) begin
          m_re      = 1'b1;
          state_nxt = ST_K_CMP;
        end else begin
          state_nxt = ST_K_NEXT;
        end
      end
      ST_K_CMP: begin
        if (qa_r == qb_r) hits_nxt = hits_r + 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_K_RD;
      end
      ST_K_NEXT: begin
        if (hits_r > best_r) begin
          best_nxt = hits_r;
          len_nxt  = k_r;
        end
        if (k_r == hi_r) begin
          col_nxt   = '0;
          clr_nxt   = '0;
          state_nxt = ST_C_CLR;
        end else begin
          k_nxt     = k_r + 1'b1;
          i_nxt     = '0;
          hits_nxt  = '0;
          state_nxt = ST_K_RD;
        end
      end
      ST_C_CLR: begin
        h_we    = 1'b1;
        h_wa    = clr_r;
        h_wd    = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == 8'hFF) begin
          i_nxt     = IW'(col_r);
          state_nxt = ST_H_RD;
        end
      end
      ST_H_RD: begin
        if (i_r < IW'(cnt_r)) begin
          m_re      = 1'b1;
          state_nxt = ST_H_HR;
        end else begin
          i_nxt     = IW'(col_r);
          bestc_nxt = '0;
          val_nxt   = '0;
          state_nxt = ST_S_RD;
        end
      end
      ST_H_HR: begin
        h_re      = 1'b1;
        state_nxt = ST_H_WR;
      end
      ST_H_WR: begin
        h_we      = 1'b1;
        i_nxt     = i_step;
        state_nxt = ST_H_RD;
      end
      ST_S_RD: begin
        if (i_r < IW'(cnt_r)) begin
          m_re      = 1'b1;
          state_nxt = ST_S_HR;
        end else begin
          ov_nxt    = 1'b1;
          okb_nxt   = val_r ^ guess;
          opos_nxt  = 4'(col_r);
          olen_nxt  = 5'(len_r);
          oovf_nxt  = ovf_r;
          olast_nxt = last_col;
          state_nxt = ST_EMIT;
        end
      end
      ST_S_HR: begin
        h_re      = 1'b1;
        state_nxt = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (hq_r > bestc_r) begin
          bestc_nxt = hq_r;
          val_nxt   = qa_r;
        end
        i_nxt     = i_step;
        state_nxt = ST_S_RD;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (last_col) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + 1'b1;
            clr_nxt   = '0;
            state_nxt = ST_C_CLR;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/xvkr_checker.sv =====
// Port-level checker for the XOR key recovery unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module xvkr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  `XV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `XV_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready)
  `XV_ASSERT_NEXT(a_busy_mid_key, out_valid && out_ready && !out_last, !in_ready)
  `XV_ASSERT_IMPL(a_no_load_while_out, out_valid, !in_ready)

endmodule

bind xor_vigenere_key_recovery_unit xvkr_checker u_xvkr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_key_byte)
);
